>>> rtl/jsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_pkg
// shared types, character codes and helpers for the json string field
// extractor
// ----------------------------------------------------------------------------
package jsfe_pkg;

	localparam int KEY_BYTES = 8;
	localparam int LEN_W     = 4;
	localparam int WIN_DEPTH = KEY_BYTES + 1;
	localparam int HEX_W     = 3;

	typedef logic [7:0]       byte_t;
	typedef logic [LEN_W-1:0] key_len_t;
	typedef logic [HEX_W-1:0] hex_cnt_t;

	// register indexes on the configuration port
	localparam logic REG_KEY_BYTES  = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	localparam byte_t CH_QUOTE     = 8'h22;
	localparam byte_t CH_BACKSLASH = 8'h5C;
	localparam byte_t CH_COLON     = 8'h3A;
	localparam byte_t CH_SPACE     = 8'h20;
	localparam byte_t CH_TAB       = 8'h09;
	localparam byte_t CH_LF        = 8'h0A;
	localparam byte_t CH_CR        = 8'h0D;
	localparam byte_t CH_BS        = 8'h08;
	localparam byte_t CH_FF        = 8'h0C;
	localparam byte_t CH_N         = 8'h6E;
	localparam byte_t CH_R         = 8'h72;
	localparam byte_t CH_T         = 8'h74;
	localparam byte_t CH_B         = 8'h62;
	localparam byte_t CH_F         = 8'h66;
	localparam byte_t CH_U         = 8'h75;

	localparam hex_cnt_t HEX_DIGITS = 3'd4;

	typedef enum logic [2:0] {
		PH_SEARCH   = 3'd0,
		PH_COLON    = 3'd1,
		PH_BLANKS   = 3'd2,
		PH_VALUE    = 3'd3,
		PH_ESCAPE   = 3'd4,
		PH_HEX      = 3'd5,
		PH_FINISHED = 3'd6
	} phase_t;

	function automatic byte_t unescape(input byte_t c);
		byte_t r;
		case (c)
			CH_N:    r = CH_LF;
			CH_R:    r = CH_CR;
			CH_T:    r = CH_TAB;
			CH_B:    r = CH_BS;
			CH_F:    r = CH_FF;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/json_string_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor
// finds a quoted key in a byte stream and returns the unescaped string value
// that follows it, one byte per result beat, closed by a status beat
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | dir | handshake
//  --------+--------------------------------------------+-----+--------------
//  in      | data_byte, end_of_message                  | in  | in_valid/in_stall
//  out     | value_byte, done_res, found                | out | out_valid/out_stall
//  cfg     | cfg_index, cfg_data                        | in  | cfg_valid/cfg_ready
//
//  one input byte per cycle sustained while out_stall does not hold the result
//  register; a byte lands in the input register, is parsed in the following
//  cycle and its result beat is loaded into the result register when the
//  input register moves forward
//  the parse step is the phase machine plus the window compare against the key
//  reset clears the phase, the \u counter, the byte window and the key registers
//  out_stall holds the result register; in_stall rises only when the input
//  register is full and cannot move forward
//
module json_string_field_extractor
	import jsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	// result beats out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  value_byte,
	output logic        done_res,
	output logic        found,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	// configuration
	logic [8*KEY_BYTES-1:0] key_bytes_q;
	key_len_t               key_len_q;

	// input register
	logic  valid_s1;
	byte_t byte_s1;
	logic  eom_s1;

	// parse state
	phase_t   phase_q, phase_d;
	hex_cnt_t hex_q, hex_d;
	byte_t    win_q [WIN_DEPTH];

	// result register
	logic  out_valid_q;
	byte_t value_byte_q;
	logic  done_q;
	logic  found_q;

	logic                 adv;
	logic [WIN_DEPTH-1:0] match_len;
	logic                 needle;
	logic                 emit_byte;
	logic                 emit_done;
	logic                 emit_found;
	byte_t                emit_val;
	logic                 has_result;

	// the input register moves on whenever the result register is free or draining
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q <= '0;
			key_len_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_BYTES:  key_bytes_q <= cfg_data[8*KEY_BYTES-1:0];
				REG_KEY_LENGTH: begin
					// lengths above KEY_BYTES saturate to KEY_BYTES
					if (cfg_data[LEN_W-1:0] > key_len_t'(KEY_BYTES))
						key_len_q <= key_len_t'(KEY_BYTES);
					else
						key_len_q <= cfg_data[LEN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
	end

	// ---------------- key window compare ----------------
	// one candidate per key length: the newest bytes spell the key in order,
	// key byte 0 oldest, with a quote just before it
	always_comb begin
		match_len = '0;
		for (int l = 0; l < WIN_DEPTH; l++) begin
			match_len[l] = (win_q[l] == CH_QUOTE);
			for (int j = 0; j < l; j++) begin
				if (win_q[l-1-j] != key_bytes_q[8*j +: 8])
					match_len[l] = 1'b0;
			end
		end
	end

	assign needle = (byte_s1 == CH_QUOTE) && match_len[key_len_q];

	// ---------------- phase machine: next state ----------------
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		case (phase_q)
			PH_SEARCH: if (needle) phase_d = PH_COLON;
			PH_COLON:  if (byte_s1 == CH_COLON) phase_d = PH_BLANKS;
			PH_BLANKS: begin
				if (byte_s1 == CH_QUOTE)
					phase_d = PH_VALUE;
				else if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB)
					phase_d = PH_FINISHED;
			end
			PH_VALUE: begin
				if (byte_s1 == CH_BACKSLASH)
					phase_d = PH_ESCAPE;
				else if (byte_s1 == CH_QUOTE)
					phase_d = PH_FINISHED;
			end
			PH_ESCAPE: begin
				if (byte_s1 == CH_U) begin
					hex_d   = HEX_DIGITS;
					phase_d = PH_HEX;
				end else begin
					phase_d = PH_VALUE;
				end
			end
			PH_HEX: begin
				hex_d = hex_q - hex_cnt_t'(1);
				if (hex_q == hex_cnt_t'(1)) phase_d = PH_VALUE;
			end
			default: ;
		endcase
		// final byte of a message always starts over
		if (eom_s1) begin
			phase_d = PH_SEARCH;
			hex_d   = '0;
		end
	end

	// ---------------- phase machine: outputs ----------------
	always_comb begin
		emit_byte  = 1'b0;
		emit_done  = 1'b0;
		emit_found = 1'b0;
		emit_val   = '0;
		case (phase_q)
			PH_BLANKS: begin
				// anything but a blank or the opening quote is malformed
				if (byte_s1 != CH_QUOTE && byte_s1 != CH_SPACE && byte_s1 != CH_TAB)
					emit_done = 1'b1;
			end
			PH_VALUE: begin
				if (byte_s1 == CH_QUOTE) begin
					emit_done  = 1'b1;
					emit_found = 1'b1;
				end else if (byte_s1 != CH_BACKSLASH) begin
					emit_byte = 1'b1;
					emit_val  = byte_s1;
				end
			end
			PH_ESCAPE: begin
				if (byte_s1 != CH_U) begin
					emit_byte = 1'b1;
					emit_val  = unescape(byte_s1);
				end
			end
			default: ;
		endcase
		if (eom_s1) begin
			// message ends without a status: report not found, drop any value byte
			if (!emit_done && phase_q < PH_FINISHED)
				emit_done = 1'b1;
			emit_byte = 1'b0;
		end
	end

	assign has_result = emit_done || emit_byte;

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			hex_q   <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			if (eom_s1) begin
				for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
			end else begin
				win_q[0] <= byte_s1;
				for (int i = 1; i < WIN_DEPTH; i++) win_q[i] <= win_q[i-1];
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= has_result;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_byte_q <= emit_done ? '0 : emit_val;
			done_q       <= emit_done;
			found_q      <= emit_done && emit_found;
		end
	end

	assign out_valid  = out_valid_q;
	assign value_byte = value_byte_q;
	assign done_res   = done_q;
	assign found      = found_q;

	// ---------------- checks ----------------
	a_eom_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eom_s1 |=> phase_q == PH_SEARCH && hex_q == '0)
		else $error("final byte did not restart the parser");

	a_hex_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEX |-> hex_q != '0)
		else $error("\\u skip phase with an empty counter");

	a_finished_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_FINISHED |=> !out_valid_q)
		else $error("result beat after the status beat");

	a_value_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> !found_q)
		else $error("found set on a value byte beat");

	a_search_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> hex_q == '0)
		else $error("\\u counter left over in key search");

endmodule
